// File: rtl/assert_macros.svh
// Assertion helpers shared by the allocator modules.
// Each use expects signals named clk and rst_n in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int CUSTOMERS      = 3;
    localparam int RESOURCE_TYPES = 3;
    localparam int MAX_TYPES      = 4;

    localparam int CUST_W = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int CNT_W  = $clog2(CUSTOMERS + 1);
    // Work sums hold the pool plus every allocation without wrapping.
    localparam int WORK_W = $clog2(256 * (CUSTOMERS + 1));

    localparam logic [1:0] KIND_SET_POOL = 2'd0;
    localparam logic [1:0] KIND_LOAD     = 2'd1;
    localparam logic [1:0] KIND_REQUEST  = 2'd2;
    localparam logic [1:0] KIND_RELEASE  = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NEED   = 3'd1;
    localparam logic [2:0] ST_AVAIL  = 3'd2;
    localparam logic [2:0] ST_UNSAFE = 3'd3;
    localparam logic [2:0] ST_ALLOC  = 3'd4;

    typedef logic [RESOURCE_TYPES-1:0][7:0] row_t;
    typedef logic [MAX_TYPES-1:0][7:0]      amt_in_t;

    typedef struct packed {
        logic              latch;
        logic              use_scan;
        logic [CUST_W-1:0] scan_idx;
        logic              pool_set;
        logic              load_claim;
        logic              release_upd;
        logic              scan_init;
        logic              scan_take;
        logic              commit;
        logic              status_we;
        logic [2:0]        status_code;
        logic              out_load;
    } bsa_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       cust_ok;
        logic [2:0] req_code;
        logic       alloc_ex;
        logic       fits;
        logic       out_free;
    } bsa_stat_t;

endpackage

// File: rtl/bsa_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsa_datapath
    import bsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bsa_cmd_t   cmd,
    output bsa_stat_t  stat,
    input  logic [1:0] in_kind,
    input  logic [1:0] in_cust,
    input  amt_in_t    in_amt,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_status,
    output logic       out_cleared
);

    row_t need_reg  [CUSTOMERS];
    row_t alloc_reg [CUSTOMERS];
    row_t pool_reg;
    logic [RESOURCE_TYPES-1:0][WORK_W-1:0] work_reg;
    logic [CUSTOMERS-1:0] done_reg;

    logic [1:0] kind_reg;
    logic [1:0] cust_reg;
    row_t       amt_reg;
    logic [2:0] status_reg;

    logic       out_valid_reg;
    logic [2:0] out_status_reg;
    logic       out_cleared_reg;

    logic [CUST_W-1:0] cust_idx;
    logic [CUST_W-1:0] row_sel;
    logic              cust_ok;
    logic              is_cust;
    row_t              need_row;
    row_t              alloc_row;
    row_t              tneed_row;
    row_t              talloc_row;
    row_t              pool_minus;
    row_t              pool_plus;
    logic [8:0]        sum_a;
    logic [8:0]        sum_p;
    logic              found;
    logic [2:0]        req_code;
    logic              alloc_ex;
    logic              fits;
    logic              cleared;

    assign cust_idx  = CUST_W'(cust_reg);
    assign cust_ok   = (32'(cust_reg) < 32'(CUSTOMERS));
    assign row_sel   = cmd.use_scan ? cmd.scan_idx : cust_idx;
    assign is_cust   = (row_sel == cust_idx);
    assign need_row  = need_reg[row_sel];
    assign alloc_row = alloc_reg[row_sel];

    // Tentative row: the requesting customer's row with the request applied.
    always_comb
    begin
        for (int r = 0; r < RESOURCE_TYPES; r++)
        begin
            sum_a = {1'b0, alloc_row[r]} + {1'b0, amt_reg[r]};
            sum_p = {1'b0, pool_reg[r]} + {1'b0, amt_reg[r]};
            tneed_row[r]  = is_cust ? (need_row[r] - amt_reg[r]) : need_row[r];
            talloc_row[r] = is_cust ? (sum_a[8] ? 8'hFF : sum_a[7:0]) : alloc_row[r];
            pool_minus[r] = pool_reg[r] - amt_reg[r];
            pool_plus[r]  = sum_p[8] ? 8'hFF : sum_p[7:0];
        end
    end

    // First failing type decides between exceeds-need and exceeds-pool.
    always_comb
    begin
        req_code = ST_OK;
        found    = 1'b0;
        alloc_ex = 1'b0;
        fits     = ~done_reg[row_sel];
        cleared  = cust_ok;
        for (int r = 0; r < RESOURCE_TYPES; r++)
        begin
            if (!found)
            begin
                if (amt_reg[r] > need_row[r])
                begin
                    req_code = ST_NEED;
                    found    = 1'b1;
                end
                else if (amt_reg[r] > pool_reg[r])
                begin
                    req_code = ST_AVAIL;
                    found    = 1'b1;
                end
            end
            if (amt_reg[r] > alloc_row[r])
                alloc_ex = 1'b1;
            if (WORK_W'(tneed_row[r]) > work_reg[r])
                fits = 1'b0;
            if (need_row[r] != 8'd0)
                cleared = 1'b0;
        end
    end

    assign stat.kind     = kind_reg;
    assign stat.cust_ok  = cust_ok;
    assign stat.req_code = req_code;
    assign stat.alloc_ex = alloc_ex;
    assign stat.fits     = fits;
    assign stat.out_free = ~out_valid_reg | out_ready;

    // Captured request, status, work sums and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= in_kind;
            cust_reg <= in_cust;
            for (int r = 0; r < RESOURCE_TYPES; r++)
                amt_reg[r] <= in_amt[r];
        end
        if (cmd.status_we)
            status_reg <= cmd.status_code;
        if (cmd.out_load)
        begin
            out_status_reg  <= status_reg;
            out_cleared_reg <= cleared;
        end
        if (cmd.scan_init)
        begin
            for (int r = 0; r < RESOURCE_TYPES; r++)
                work_reg[r] <= WORK_W'(pool_minus[r]);
        end
        else if (cmd.scan_take)
        begin
            for (int r = 0; r < RESOURCE_TYPES; r++)
                work_reg[r] <= work_reg[r] + WORK_W'(talloc_row[r]);
        end
    end

    // Allocator state tables, scan done flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CUSTOMERS; c++)
            begin
                need_reg[c]  <= '0;
                alloc_reg[c] <= '0;
            end
            pool_reg      <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.scan_init)
                done_reg <= '0;
            else if (cmd.scan_take)
                done_reg[row_sel] <= 1'b1;

            if (cmd.pool_set)
                pool_reg <= amt_reg;
            else if (cmd.load_claim)
            begin
                need_reg[cust_idx]  <= amt_reg;
                alloc_reg[cust_idx] <= '0;
            end
            else if (cmd.release_upd)
            begin
                pool_reg <= pool_plus;
                for (int r = 0; r < RESOURCE_TYPES; r++)
                    alloc_reg[cust_idx][r] <= alloc_row[r] - amt_reg[r];
            end
            else if (cmd.commit)
            begin
                pool_reg            <= pool_minus;
                need_reg[cust_idx]  <= tneed_row;
                alloc_reg[cust_idx] <= talloc_row;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_cleared = out_cleared_reg;

    `ASSERT_IMP(a_take_once, cmd.scan_take, !done_reg[row_sel], "customer finished twice in scan")
    `ASSERT_IMP(a_commit_ok, cmd.commit, status_reg == ST_OK && cust_ok, "commit of failed request")
    `ASSERT_NEXT(a_out_load, cmd.out_load, out_valid_reg, "loaded result not presented")

endmodule

// File: rtl/bsa_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  bsa_stat_t stat,
    output bsa_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [CUST_W-1:0] LAST_IDX = CUST_W'(CUSTOMERS - 1);
    localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(CUSTOMERS - 1);

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CUST_W-1:0] scan_idx_reg;
    logic [CUST_W-1:0] scan_idx_next;
    logic [CNT_W-1:0]  fit_cnt_reg;
    logic [CNT_W-1:0]  fit_cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.scan_idx  = scan_idx_reg;
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        fit_cnt_next  = fit_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.status_we   = 1'b1;
                cmd.status_code = ST_OK;
                state_next      = S_DONE;
                case (stat.kind)
                    KIND_SET_POOL: cmd.pool_set = 1'b1;
                    KIND_LOAD:     cmd.load_claim = stat.cust_ok;
                    KIND_REQUEST:
                    begin
                        if (stat.cust_ok)
                        begin
                            if (stat.req_code != ST_OK)
                                cmd.status_code = stat.req_code;
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                scan_idx_next = '0;
                                fit_cnt_next  = '0;
                                state_next    = S_SCAN;
                            end
                        end
                    end
                    KIND_RELEASE:
                    begin
                        if (stat.cust_ok)
                        begin
                            if (stat.alloc_ex)
                                cmd.status_code = ST_ALLOC;
                            else
                                cmd.release_upd = 1'b1;
                        end
                    end
                    default: cmd.status_code = ST_OK;
                endcase
            end
            S_SCAN:
            begin
                // One customer row per cycle; restart the pass after each finisher.
                cmd.use_scan = 1'b1;
                if (stat.fits)
                begin
                    cmd.scan_take = 1'b1;
                    scan_idx_next = '0;
                    if (fit_cnt_reg == LAST_CNT)
                        state_next = S_COMMIT;
                    else
                        fit_cnt_next = fit_cnt_reg + 1'b1;
                end
                else if (scan_idx_reg == LAST_IDX)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = ST_UNSAFE;
                    state_next      = S_DONE;
                end
                else
                    scan_idx_next = scan_idx_reg + 1'b1;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            fit_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            fit_cnt_reg  <= fit_cnt_next;
        end
    end

    `ASSERT_IMP(a_scan_kind, state_reg == S_SCAN, stat.kind == KIND_REQUEST && stat.cust_ok, "scan without valid request")
    `ASSERT_IMP(a_scan_idx, state_reg == S_SCAN, scan_idx_reg <= LAST_IDX, "scan index out of range")
    `ASSERT_IMP(a_fit_cnt, state_reg == S_SCAN, fit_cnt_reg <= LAST_CNT, "finisher count overrun")

endmodule

// File: rtl/bankers_safe_allocator_core.sv
// Each request is captured, checked in the execute state and passed to the output register
// in the done state; set, load, release, refused and out-of-range requests go straight to
// done, a granted request adds the safety scan and a commit state, and an unsafe denial
// adds the scan only. One request is handled at a time; the next is accepted once the
// result is registered, while that result may still wait.
// Reset (rst_n, async, active low) clears need, allocation and pool tables and the controller.
`timescale 1ns / 1ps

module bankers_safe_allocator_core
    import bsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] customer, [9:2] amount_0, [17:10] amount_1, [25:18] amount_2,
    // [33:26] amount_3, [39:34] zero
    input  logic [39:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [3] need_cleared, [7:4] zero
    output logic [7:0]  m_tdata
);

    bsa_cmd_t   cmd;
    bsa_stat_t  stat;
    amt_in_t    in_amt;
    logic [2:0] out_status;
    logic       out_cleared;

    // Split the request payload into per-type amounts; types not built are dropped
    // inside the datapath.
    always_comb
    begin
        for (int r = 0; r < MAX_TYPES; r++)
            in_amt[r] = s_tdata[2 + 8 * r +: 8];
    end

    // Controller: sequences one request through check, safety scan, commit and
    // result hand-off.
    bsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: tables, tentative-state compare, work sums and output register.
    bsa_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_tuser),
        .in_cust     (s_tdata[1:0]),
        .in_amt      (in_amt),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_cleared (out_cleared)
    );

    // Pack the result; upper bits stay zero.
    assign m_tdata = {4'b0000, out_cleared, out_status};

endmodule
